>>> hdl/hve_pkg.sv
// Shared constants and types for the haptic velocity estimator.
`default_nettype none

package hve_pkg;

  localparam int COEF_FRAC_BITS = 28;

  localparam int NUM_AXES   = 3;
  localparam int AXIS_W     = 2;
  localparam int HIST_D     = 3;
  localparam int POS_W      = 21;
  localparam int VEL_W      = 32;
  localparam int GAIN_W     = 16;
  localparam int COEF_W     = 32;
  localparam int DIFF_W     = 25;
  localparam int RAW_W      = 40;
  localparam int DIGIT_W    = 16;
  localparam int NUM_DIGITS = 3;
  localparam int DIGIT_IDX_W = 2;
  localparam int OPND_W     = NUM_DIGITS * DIGIT_W;
  localparam int PROD_W     = COEF_W + DIGIT_W + 1;
  localparam int ACC_W      = 76;
  localparam int Q_W        = ACC_W - COEF_FRAC_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [VEL_W-1:0] VEL_LIMIT = 32'sd2000000000;
  localparam logic signed [POS_W-1:0] POS_MAX   = 21'sd1048575;
  localparam logic signed [POS_W-1:0] POS_MIN   = {1'b1, {(POS_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]        GAIN_RST      = 16'd500;
  localparam logic signed [COEF_W-1:0] COEF_OUTER_RST = 32'sd58948;
  localparam logic signed [COEF_W-1:0] COEF_INNER_RST = 32'sd176845;
  localparam logic signed [COEF_W-1:0] FB_FIRST_RST  = -32'sd737875381;
  localparam logic signed [COEF_W-1:0] FB_SECOND_RST = 32'sd678658520;
  localparam logic signed [COEF_W-1:0] FB_THIRD_RST  = -32'sd208735411;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_GAIN  = 3'd0,
    REG_COEF_OUTER = 3'd1,
    REG_COEF_INNER = 3'd2,
    REG_FB_FIRST   = 3'd3,
    REG_FB_SECOND  = 3'd4,
    REG_FB_THIRD   = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

>>> hdl/haptic_velocity_estimator.sv
// Top level: axis remap, backward difference and third-order IIR low-pass per axis.
// A new input beat is taken only when idle, after all three axes are done and the result
// has gone to the output register. Each axis passes through the shared 32x17 digit
// multiplier (7 filter terms x 3 sixteen-bit digits) and through the difference, gain,
// rounding, saturation and history update steps.
// Reset (rst_n low, synchronous): histories to zero, registers to defaults, no beat pending.
`default_nettype none

module haptic_velocity_estimator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hve_pkg::POS_W-1:0]     in_dev_x,
  input  logic signed [hve_pkg::POS_W-1:0]     in_dev_y,
  input  logic signed [hve_pkg::POS_W-1:0]     in_dev_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [hve_pkg::POS_W-1:0]     out_pos_x,
  output logic signed [hve_pkg::POS_W-1:0]     out_pos_y,
  output logic signed [hve_pkg::POS_W-1:0]     out_pos_z,
  output logic signed [hve_pkg::VEL_W-1:0]     out_vel_x,
  output logic signed [hve_pkg::VEL_W-1:0]     out_vel_y,
  output logic signed [hve_pkg::VEL_W-1:0]     out_vel_z,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hve_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [hve_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import hve_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIFF  = 8'b0000_0010,
    ST_GAIN  = 8'b0000_0100,
    ST_MAC   = 8'b0000_1000,
    ST_ROUND = 8'b0001_0000,
    ST_SAT   = 8'b0010_0000,
    ST_ROT   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    TERM_V0 = 3'd0,
    TERM_V3 = 3'd1,
    TERM_V1 = 3'd2,
    TERM_V2 = 3'd3,
    TERM_Y1 = 3'd4,
    TERM_Y2 = 3'd5,
    TERM_Y3 = 3'd6
  } term_t;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0]   Q_HI       = Q_W'(VEL_LIMIT);
  localparam logic signed [Q_W-1:0]   Q_LO       = -Q_HI;

  state_t                    state_r, state_nxt;
  logic [AXIS_W-1:0]         axis_r;
  term_t                     term_r;
  logic [DIGIT_IDX_W-1:0]    digit_r;
  logic                      out_valid_r;
  logic                      out_load;

  logic [GAIN_W-1:0]         gain_r;
  logic signed [COEF_W-1:0]  coef_outer_r, coef_inner_r;
  logic signed [COEF_W-1:0]  fb_first_r, fb_second_r, fb_third_r;

  // slot 0 of every per-axis array always holds the axis in work
  logic signed [POS_W-1:0]   pos_r   [NUM_AXES];
  logic signed [POS_W-1:0]   prev_r  [NUM_AXES];
  logic signed [POS_W-1:0]   older_r [NUM_AXES];
  logic signed [RAW_W-1:0]   rv_r    [NUM_AXES][HIST_D];
  logic signed [VEL_W-1:0]   fv_r    [NUM_AXES][HIST_D];

  logic signed [DIFF_W-1:0]  d_r, d_nxt;
  logic signed [RAW_W-1:0]   v0_r, v0_nxt;
  logic signed [DIFF_W+GAIN_W:0] gain_prod;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt, acc_base;
  logic signed [VEL_W-1:0]   y_r, y_nxt;
  logic signed [Q_W-1:0]     q_val;

  logic signed [RAW_W-1:0]   opnd;
  logic signed [OPND_W-1:0]  opnd_ext;
  logic [DIGIT_W-1:0]        digit_bits;
  logic signed [DIGIT_W:0]   digit_s;
  logic signed [COEF_W-1:0]  coef_sel;
  logic                      sub_sel;
  logic signed [PROD_W-1:0]  prod;

  logic signed [POS_W-1:0]   pos_y_in;
  logic signed [DIFF_W-1:0]  p0_e, p1_e, p2_e;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // negating the most negative z saturates
  assign pos_y_in = (in_dev_z == POS_MIN) ? POS_MAX : -in_dev_z;

  assign p0_e  = DIFF_W'(pos_r[0]);
  assign p1_e  = DIFF_W'(prev_r[0]);
  assign p2_e  = DIFF_W'(older_r[0]);
  assign d_nxt = (p0_e <<< 1) + p0_e - (p1_e <<< 2) + p2_e;

  assign gain_prod = d_r * $signed({1'b0, gain_r});
  assign v0_nxt    = RAW_W'(gain_prod);

  always_comb begin
    opnd     = v0_r;
    coef_sel = coef_outer_r;
    sub_sel  = 1'b0;
    case (term_r)
      TERM_V0: begin
        opnd = v0_r;            coef_sel = coef_outer_r; sub_sel = 1'b0;
      end
      TERM_V3: begin
        opnd = rv_r[0][2];      coef_sel = coef_outer_r; sub_sel = 1'b0;
      end
      TERM_V1: begin
        opnd = rv_r[0][0];      coef_sel = coef_inner_r; sub_sel = 1'b0;
      end
      TERM_V2: begin
        opnd = rv_r[0][1];      coef_sel = coef_inner_r; sub_sel = 1'b0;
      end
      TERM_Y1: begin
        opnd = RAW_W'(fv_r[0][0]); coef_sel = fb_first_r; sub_sel = 1'b1;
      end
      TERM_Y2: begin
        opnd = RAW_W'(fv_r[0][1]); coef_sel = fb_second_r; sub_sel = 1'b1;
      end
      TERM_Y3: begin
        opnd = RAW_W'(fv_r[0][2]); coef_sel = fb_third_r; sub_sel = 1'b1;
      end
      default: begin
        opnd = v0_r;            coef_sel = coef_outer_r; sub_sel = 1'b0;
      end
    endcase
  end

  // top digit carries the sign, lower digits are unsigned
  assign opnd_ext   = OPND_W'(opnd);
  assign digit_bits = opnd_ext[digit_r*DIGIT_W +: DIGIT_W];
  assign digit_s    = (digit_r == DIGIT_IDX_W'(NUM_DIGITS - 1)) ?
                      {digit_bits[DIGIT_W-1], digit_bits} : {1'b0, digit_bits};
  assign prod       = coef_sel * digit_s;

  // Horner over digits: shift the sum up one digit at the first term of each digit
  assign acc_base = (term_r == TERM_V0) ? (acc_r <<< DIGIT_W) : acc_r;
  assign acc_nxt  = sub_sel ? (acc_base - ACC_W'(prod)) : (acc_base + ACC_W'(prod));

  assign q_val = acc_r[ACC_W-1:COEF_FRAC_BITS];
  always_comb begin
    if (q_val > Q_HI) begin
      y_nxt = VEL_LIMIT;
    end else if (q_val < Q_LO) begin
      y_nxt = -VEL_LIMIT;
    end else begin
      y_nxt = q_val[VEL_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_GAIN;
      ST_GAIN:  state_nxt = ST_MAC;
      ST_MAC:   if (term_r == TERM_Y3 && digit_r == '0) state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_SAT;
      ST_SAT:   state_nxt = ST_ROT;
      ST_ROT: begin
        if (axis_r == AXIS_W'(NUM_AXES - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration and filter history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      axis_r       <= '0;
      term_r       <= TERM_V0;
      digit_r      <= '0;
      out_valid_r  <= 1'b0;
      gain_r       <= GAIN_RST;
      coef_outer_r <= COEF_OUTER_RST;
      coef_inner_r <= COEF_INNER_RST;
      fb_first_r   <= FB_FIRST_RST;
      fb_second_r  <= FB_SECOND_RST;
      fb_third_r   <= FB_THIRD_RST;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_r[i]  <= '0;
        older_r[i] <= '0;
        for (int j = 0; j < HIST_D; j++) begin
          rv_r[i][j] <= '0;
          fv_r[i][j] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DIFF_GAIN:  gain_r       <= cfg_data[GAIN_W-1:0];
          REG_COEF_OUTER: coef_outer_r <= cfg_data;
          REG_COEF_INNER: coef_inner_r <= cfg_data;
          REG_FB_FIRST:   fb_first_r   <= cfg_data;
          REG_FB_SECOND:  fb_second_r  <= cfg_data;
          REG_FB_THIRD:   fb_third_r   <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == ST_GAIN) begin
        term_r  <= TERM_V0;
        digit_r <= DIGIT_IDX_W'(NUM_DIGITS - 1);
      end else if (state_r == ST_MAC) begin
        if (term_r == TERM_Y3) begin
          term_r  <= TERM_V0;
          digit_r <= digit_r - DIGIT_IDX_W'(1);
        end else begin
          term_r <= term_t'(term_r + 3'd1);
        end
      end

      // advance the axis ring: slot 0 retires to the back with its history updated
      if (state_r == ST_ROT) begin
        axis_r <= (axis_r == AXIS_W'(NUM_AXES - 1)) ? '0 : axis_r + AXIS_W'(1);
        for (int i = 0; i < NUM_AXES - 1; i++) begin
          prev_r[i]  <= prev_r[i+1];
          older_r[i] <= older_r[i+1];
          for (int j = 0; j < HIST_D; j++) begin
            rv_r[i][j] <= rv_r[i+1][j];
            fv_r[i][j] <= fv_r[i+1][j];
          end
        end
        prev_r[NUM_AXES-1]   <= pos_r[0];
        older_r[NUM_AXES-1]  <= prev_r[0];
        rv_r[NUM_AXES-1][0]  <= v0_r;
        rv_r[NUM_AXES-1][1]  <= rv_r[0][0];
        rv_r[NUM_AXES-1][2]  <= rv_r[0][1];
        fv_r[NUM_AXES-1][0]  <= y_r;
        fv_r[NUM_AXES-1][1]  <= fv_r[0][0];
        fv_r[NUM_AXES-1][2]  <= fv_r[0][1];
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic signed [POS_W-1:0] out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [VEL_W-1:0] out_vel_x_r, out_vel_y_r, out_vel_z_r;

  // datapath payload
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      pos_r[0] <= in_dev_x;
      pos_r[1] <= pos_y_in;
      pos_r[2] <= in_dev_y;
    end else if (state_r == ST_ROT) begin
      for (int i = 0; i < NUM_AXES - 1; i++) begin
        pos_r[i] <= pos_r[i+1];
      end
      pos_r[NUM_AXES-1] <= pos_r[0];
    end

    if (state_r == ST_DIFF) d_r <= d_nxt;

    if (state_r == ST_GAIN) begin
      v0_r  <= v0_nxt;
      acc_r <= '0;
    end else if (state_r == ST_MAC) begin
      acc_r <= acc_nxt;
    end else if (state_r == ST_ROUND) begin
      acc_r <= acc_r + ROUND_HALF;
    end

    if (state_r == ST_SAT) y_r <= y_nxt;

    if (out_load) begin
      out_pos_x_r <= pos_r[0];
      out_pos_y_r <= pos_r[1];
      out_pos_z_r <= pos_r[2];
      out_vel_x_r <= fv_r[0][0];
      out_vel_y_r <= fv_r[1][0];
      out_vel_z_r <= fv_r[2][0];
    end
  end

  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_pos_z = out_pos_z_r;
  assign out_vel_x = out_vel_x_r;
  assign out_vel_y = out_vel_y_r;
  assign out_vel_z = out_vel_z_r;

endmodule

`default_nettype wire

>>> hdl/hve_checker.sv
// Port-level checks for the haptic velocity estimator, bound to the top level.
`default_nettype none

module hve_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [hve_pkg::POS_W-1:0]     out_pos_x,
  input logic signed [hve_pkg::POS_W-1:0]     out_pos_y,
  input logic signed [hve_pkg::POS_W-1:0]     out_pos_z,
  input logic signed [hve_pkg::VEL_W-1:0]     out_vel_x,
  input logic signed [hve_pkg::VEL_W-1:0]     out_vel_y,
  input logic signed [hve_pkg::VEL_W-1:0]     out_vel_z
);
  import hve_pkg::*;

  // one item at a time: an input beat closes the input side
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // a fresh result coincides with the block going idle again
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the block is still busy");

  a_vel_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vel_x <= VEL_LIMIT) && (out_vel_x >= -VEL_LIMIT) &&
                  (out_vel_y <= VEL_LIMIT) && (out_vel_y >= -VEL_LIMIT) &&
                  (out_vel_z <= VEL_LIMIT) && (out_vel_z >= -VEL_LIMIT))
    else $error("velocity outside the saturation range");

  a_pos_y_negated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pos_y != POS_MIN)
    else $error("negated z not saturated");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_pos_z) &&
      $stable(out_vel_x) && $stable(out_vel_y) && $stable(out_vel_z))
    else $error("stalled result beat changed");

endmodule

bind haptic_velocity_estimator hve_checker u_hve_checker (.*);

`default_nettype wire

>>> bench/hve_motion_checker.sv
// Checker for the haptic velocity estimator: watches all three channels and predicts every result.
`timescale 1ns / 1ps

module hve_motion_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic signed [hve_pkg::POS_W-1:0]   in_dev_x,
  input  logic signed [hve_pkg::POS_W-1:0]   in_dev_y,
  input  logic signed [hve_pkg::POS_W-1:0]   in_dev_z,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic signed [hve_pkg::POS_W-1:0]   out_pos_x,
  input  logic signed [hve_pkg::POS_W-1:0]   out_pos_y,
  input  logic signed [hve_pkg::POS_W-1:0]   out_pos_z,
  input  logic signed [hve_pkg::VEL_W-1:0]   out_vel_x,
  input  logic signed [hve_pkg::VEL_W-1:0]   out_vel_y,
  input  logic signed [hve_pkg::VEL_W-1:0]   out_vel_z,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [hve_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hve_pkg::CFG_DATA_W-1:0]     cfg_data,
  output int                                 mismatches,
  output int                                 outstanding
);
  import hve_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } motion_t;

  logic [GAIN_W-1:0]        gain;
  logic signed [COEF_W-1:0] w_outer, w_inner, w_fb1, w_fb2, w_fb3;
  logic signed [POS_W-1:0]  last_pos  [NUM_AXES];
  logic signed [POS_W-1:0]  prior_pos [NUM_AXES];
  logic signed [RAW_W-1:0]  raw_hist  [NUM_AXES][HIST_D];
  logic signed [VEL_W-1:0]  filt_hist [NUM_AXES][HIST_D];
  motion_t                  expected_motion [$];
  int                       errs = 0;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Backward difference, gain and IIR step for one axis; advances that axis's history.
  function automatic logic signed [VEL_W-1:0] filter_axis(int a, logic signed [POS_W-1:0] p);
    logic signed [127:0] p0, p1, p2, g, v0, acc, q, lim;
    logic signed [127:0] co, ci, f1, f2, f3, r0, r1, r2, y1, y2, y3;
    logic signed [VEL_W-1:0] y;
    p0 = 128'(p);
    p1 = 128'(last_pos[a]);
    p2 = 128'(prior_pos[a]);
    g  = {112'd0, gain};
    v0 = (128'sd3 * p0 - 128'sd4 * p1 + p2) * g;
    co = 128'(w_outer);
    ci = 128'(w_inner);
    f1 = 128'(w_fb1);
    f2 = 128'(w_fb2);
    f3 = 128'(w_fb3);
    r0 = 128'(raw_hist[a][0]);
    r1 = 128'(raw_hist[a][1]);
    r2 = 128'(raw_hist[a][2]);
    y1 = 128'(filt_hist[a][0]);
    y2 = 128'(filt_hist[a][1]);
    y3 = 128'(filt_hist[a][2]);
    lim = 128'(VEL_LIMIT);
    acc = co * (v0 + r2) + ci * (r0 + r1) - f1 * y1 - f2 * y2 - f3 * y3;
    // round to nearest, ties up, then clamp
    q = (acc + (128'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (q > lim) begin
      y = VEL_LIMIT;
    end else if (q < -lim) begin
      y = -VEL_LIMIT;
    end else begin
      y = q[VEL_W-1:0];
    end
    prior_pos[a]    = last_pos[a];
    last_pos[a]     = p;
    raw_hist[a][2]  = raw_hist[a][1];
    raw_hist[a][1]  = raw_hist[a][0];
    raw_hist[a][0]  = v0[RAW_W-1:0];
    filt_hist[a][2] = filt_hist[a][1];
    filt_hist[a][1] = filt_hist[a][0];
    filt_hist[a][0] = y;
    return y;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : track
    motion_t want;
    motion_t got;
    if (!rst_n) begin
      gain    = GAIN_RST;
      w_outer = COEF_OUTER_RST;
      w_inner = COEF_INNER_RST;
      w_fb1   = FB_FIRST_RST;
      w_fb2   = FB_SECOND_RST;
      w_fb3   = FB_THIRD_RST;
      for (int a = 0; a < NUM_AXES; a++) begin
        last_pos[a]  = '0;
        prior_pos[a] = '0;
        for (int k = 0; k < HIST_D; k++) begin
          raw_hist[a][k]  = '0;
          filt_hist[a][k] = '0;
        end
      end
      expected_motion.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIFF_GAIN:  gain    = cfg_data[GAIN_W-1:0];
          REG_COEF_OUTER: w_outer = cfg_data;
          REG_COEF_INNER: w_inner = cfg_data;
          REG_FB_FIRST:   w_fb1   = cfg_data;
          REG_FB_SECOND:  w_fb2   = cfg_data;
          REG_FB_THIRD:   w_fb3   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want.pos_x = in_dev_x;
        // negating the most negative z saturates
        want.pos_y = (in_dev_z == POS_MIN) ? POS_MAX : -in_dev_z;
        want.pos_z = in_dev_y;
        want.vel_x = filter_axis(0, want.pos_x);
        want.vel_y = filter_axis(1, want.pos_y);
        want.vel_z = filter_axis(2, want.pos_z);
        expected_motion.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z};
        if (expected_motion.size() == 0) begin
          errs++;
          $display("%0t: result beat, expected nothing, actual pos %0d %0d %0d vel %0d %0d %0d",
                   $time, got.pos_x, got.pos_y, got.pos_z, got.vel_x, got.vel_y, got.vel_z);
        end else begin
          want = expected_motion.pop_front();
          check_field("pos_x", longint'(want.pos_x), longint'(got.pos_x));
          check_field("pos_y", longint'(want.pos_y), longint'(got.pos_y));
          check_field("pos_z", longint'(want.pos_z), longint'(got.pos_z));
          check_field("vel_x", longint'(want.vel_x), longint'(got.vel_x));
          check_field("vel_y", longint'(want.vel_y), longint'(got.vel_y));
          check_field("vel_z", longint'(want.vel_z), longint'(got.vel_z));
        end
      end
    end
    mismatches  <= errs;
    outstanding <= expected_motion.size();
  end

endmodule

>>> bench/tb_haptic_velocity_estimator.sv
// Testbench top for the haptic velocity estimator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_haptic_velocity_estimator;
  import hve_pkg::*;

  localparam int MOVE_LIMIT  = 1000000;
  localparam int HOLD_AT     = 350;
  localparam int HOLD_CYCLES = 800;
  localparam int CALM_FROM   = 900;
  localparam int CALM_TO     = 1100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic signed [POS_W-1:0]  in_dev_x = '0;
  logic signed [POS_W-1:0]  in_dev_y = '0;
  logic signed [POS_W-1:0]  in_dev_z = '0;
  logic                     out_ready = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_ready, out_valid, cfg_ready;
  logic signed [POS_W-1:0]  out_pos_x, out_pos_y, out_pos_z;
  logic signed [VEL_W-1:0]  out_vel_x, out_vel_y, out_vel_z;
  int                       mismatches, outstanding;
  bit                       steady = 1'b0;
  int                       track_x = 0, track_y = 0, track_z = 0;

  haptic_velocity_estimator uut (.*);

  hve_motion_checker checker_i (.*);

  always #2 clk = ~clk;

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off, one stretch always ready.
  initial begin : drain_side
    int seen;
    bit held;
    seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (seen == HOLD_AT && !held) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else begin
        out_ready <= (seen >= CALM_FROM && seen < CALM_TO) ? 1'b1
                                                           : ($urandom_range(0, 99) >= 32);
      end
    end
  end

  task automatic send_move(input logic signed [POS_W-1:0] x, y, z);
    in_valid <= 1'b1;
    in_dev_x <= x;
    in_dev_y <= y;
    in_dev_z <= z;
    do @(posedge clk); while (!in_ready);
    if (!steady && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Upper bits of the gain beat are junk the block must drop.
  task automatic load_filter(input logic [GAIN_W-1:0] g,
                             input logic [COEF_W-1:0] co, ci, f1, f2, f3);
    write_reg(REG_DIFF_GAIN, {16'($urandom), g});
    write_reg(REG_COEF_OUTER, co);
    write_reg(REG_COEF_INNER, ci);
    write_reg(REG_FB_FIRST, f1);
    write_reg(REG_FB_SECOND, f2);
    write_reg(REG_FB_THIRD, f3);
  endtask

  // Hold the sender until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic int wander(int p, int m);
    int n;
    n = p + int'($urandom_range(0, 2 * m)) - m;
    if (n > MOVE_LIMIT) n = MOVE_LIMIT;
    if (n < -MOVE_LIMIT) n = -MOVE_LIMIT;
    return n;
  endfunction

  // Mostly a smooth trajectory, with some full-range jumps mixed in.
  task automatic run_motion(int count, int max_step);
    logic signed [POS_W-1:0] x, y, z;
    repeat (count) begin
      if ($urandom_range(0, 99) < 20) begin
        x = POS_W'($urandom);
        y = POS_W'($urandom);
        z = POS_W'($urandom);
      end else begin
        track_x = wander(track_x, max_step);
        track_y = wander(track_y, max_step);
        track_z = wander(track_z, max_step);
        x = POS_W'(track_x);
        y = POS_W'(track_y);
        z = POS_W'(track_z);
      end
      send_move(x, y, z);
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_move('0, '0, '0);
    send_move(POS_MAX, POS_MAX, POS_MAX);
    send_move(POS_MIN, POS_MIN, POS_MIN);
    send_move(POS_W'(MOVE_LIMIT), POS_W'(-MOVE_LIMIT), POS_W'(MOVE_LIMIT));
    send_move(POS_W'(-MOVE_LIMIT), POS_W'(MOVE_LIMIT), POS_W'(-MOVE_LIMIT));
    send_move('0, '0, POS_MIN);
    send_move('0, '0, POS_MAX);
    // alternate extremes for the largest backward difference
    for (int i = 0; i < 6; i++) begin
      if (i % 2 == 0) send_move(POS_MAX, POS_MIN, POS_MAX);
      else send_move(POS_MIN, POS_MAX, POS_MIN);
    end
    repeat (5) send_move(POS_W'(12345), POS_W'(-6789), POS_W'(424242));
    for (int i = 1; i <= 5; i++) begin
      send_move(POS_W'(i * 1000), POS_W'(-i * 1000), POS_W'(i * 2000));
    end

    run_motion(280, 2000);
    drain_results();

    load_filter(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000);
    run_motion(100, 300000);
    drain_results();

    load_filter(16'd0, $urandom, $urandom, $urandom, $urandom, $urandom);
    // writes to unused indexes must not disturb anything
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    run_motion(60, 5000);
    drain_results();

    load_filter(16'd1, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_motion(150, 50000);
    drain_results();

    // plain moving average, no feedback
    load_filter(16'($urandom), 32'h0400_0000, 32'h0400_0000, 32'h0, 32'h0, 32'h0);
    run_motion(200, 1000);
    drain_results();

    load_filter(16'($urandom), 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'hFFFF_FFFF);
    run_motion(60, 20000);
    drain_results();

    load_filter(GAIN_RST, COEF_OUTER_RST, COEF_INNER_RST, FB_FIRST_RST,
                FB_SECOND_RST, FB_THIRD_RST);
    run_motion(150, 3000);
    steady = 1'b1;
    run_motion(200, 3000);
    steady = 1'b0;
    run_motion(150, 100000);

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
